// File: design/icfm_pkg.sv
// Package for the input capture frequency meter.
// Holds widths, word types, opcodes and the controller-to-datapath command struct.
// No dependencies.
package icfm_pkg;

  localparam int CAP_W     = 16;
  localparam int REF_W     = 27;
  localparam int FREQ_W    = 30;
  localparam int NUM_W     = REF_W + 4;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [REF_W-1:0]  REF_RESET = REF_W'(10000);
  localparam logic [FREQ_W-1:0] FREQ_MAX  = {FREQ_W{1'b1}};

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [CAP_W-1:0] capture_value;
  } in_word_t;

  typedef struct packed {
    logic [CAP_W-1:0]  period_ticks;
    logic [FREQ_W-1:0] frequency_tenths;
    logic              timed_out;
    logic              zero_period;
  } out_word_t;

  typedef struct packed {
    logic store_first;
    logic clear_first;
    logic div_start;
    logic div_step;
    logic load_out;
    logic timeout;
  } cmd_t;

endpackage

// File: design/icfm_ctrl.sv
// Controller of the input capture frequency meter.
// Sequences capture phases, the serial divide and the output register load.
// Depends on icfm_pkg.
module icfm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  output icfm_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       awaiting_r, awaiting_nxt;
  logic                       timeout_r, timeout_nxt;
  logic [icfm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       in_acc;
  logic                       slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    awaiting_nxt = awaiting_r;
    timeout_nxt  = timeout_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.timeout  = timeout_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == icfm_pkg::OP_TIMEOUT) begin
            cmd.clear_first = 1'b1;
            awaiting_nxt    = 1'b0;
            timeout_nxt     = 1'b1;
            state_nxt       = ST_EMIT;
          end else if (!awaiting_r) begin
            cmd.store_first = 1'b1;
            awaiting_nxt    = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            awaiting_nxt  = 1'b0;
            timeout_nxt   = 1'b0;
            cnt_nxt       = icfm_pkg::CNT_W'(icfm_pkg::DIV_STEPS - 1);
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      timeout_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      timeout_r   <= timeout_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/icfm_dp.sv
// Datapath of the input capture frequency meter.
// Holds the reference clock register, capture state, a restoring divider and the output word.
// Depends on icfm_pkg.
module icfm_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [icfm_pkg::REF_W-1:0] cfg_wr_data,
  input  icfm_pkg::in_word_t         in_word,
  input  icfm_pkg::cmd_t             cmd,
  output icfm_pkg::out_word_t        out_word
);

  logic [icfm_pkg::REF_W-1:0]  ref_r;
  logic [icfm_pkg::CAP_W-1:0]  first_r;
  logic [icfm_pkg::CAP_W-1:0]  last_period_r;
  logic                        zero_r;
  logic [icfm_pkg::CAP_W-1:0]  div_r;
  logic [icfm_pkg::CAP_W-1:0]  rem_r, rem_nxt;
  logic [icfm_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  icfm_pkg::out_word_t         out_r, out_nxt;

  logic [icfm_pkg::CAP_W-1:0]  period;
  logic [icfm_pkg::NUM_W-1:0]  num;
  logic [icfm_pkg::CAP_W:0]    shifted;
  logic [icfm_pkg::CAP_W:0]    div_ext;
  logic [icfm_pkg::CAP_W:0]    diff;
  logic                        ge;
  logic                        sat;
  logic [icfm_pkg::FREQ_W-1:0] freq;

  assign period  = in_word.capture_value - first_r;
  assign num     = icfm_pkg::NUM_W'({ref_r, 3'b000}) + icfm_pkg::NUM_W'({ref_r, 1'b0});
  assign shifted = {rem_r, quo_r[icfm_pkg::NUM_W-1]};
  assign div_ext = {1'b0, div_r};
  assign ge      = (shifted >= div_ext);
  assign diff    = shifted - div_ext;
  assign sat     = |quo_r[icfm_pkg::NUM_W-1:icfm_pkg::FREQ_W];

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = num;
    end else if (cmd.div_step) begin
      rem_nxt = ge ? diff[icfm_pkg::CAP_W-1:0] : shifted[icfm_pkg::CAP_W-1:0];
      quo_nxt = {quo_r[icfm_pkg::NUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (zero_r || sat) begin
      freq = icfm_pkg::FREQ_MAX;
    end else begin
      freq = quo_r[icfm_pkg::FREQ_W-1:0];
    end
    out_nxt              = out_r;
    if (cmd.load_out) begin
      out_nxt.period_ticks = last_period_r;
      if (cmd.timeout) begin
        out_nxt.frequency_tenths = '0;
        out_nxt.timed_out        = 1'b1;
        out_nxt.zero_period      = 1'b0;
      end else begin
        out_nxt.frequency_tenths = freq;
        out_nxt.timed_out        = 1'b0;
        out_nxt.zero_period      = zero_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r         <= icfm_pkg::REF_RESET;
      first_r       <= '0;
      last_period_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        ref_r <= cfg_wr_data;
      end
      if (cmd.clear_first) begin
        first_r <= '0;
      end else if (cmd.store_first) begin
        first_r <= in_word.capture_value;
      end
      if (cmd.div_start) begin
        last_period_r <= period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_r  <= period;
      zero_r <= (period == '0);
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    out_r <= out_nxt;
  end

  assign out_word = out_r;

endmodule

// File: design/input_capture_frequency_meter.sv
// Top level of the input capture frequency meter.
// Instantiates icfm_ctrl and icfm_dp; depends on icfm_pkg.
//
// Usage: the input channel (in_valid, in_stall, in_word) carries capture words
// and overflow timeout words. The first capture word is stored and gives no
// result. The second gives one result word on the output channel (out_valid,
// out_stall, out_word) with the period and ten times cfg_wr_data divided by it.
// A timeout word gives one result with zero frequency and the last period.
// The reference clock register is written with cfg_wr_en and cfg_wr_data.
// A timeout word goes straight to its result load. A second capture runs a
// restoring divider over the 31-bit numerator, one quotient bit per cycle,
// before its result load, which waits for a free output slot. A first
// capture is only stored. The input is stalled while a divide or a result
// load is in progress; a new word is taken while an earlier result still waits.
// Reset clears the phase, the stored capture and the last period, and loads
// 10000 into the reference clock register. A stalled result holds, and the
// next result waits for it to be taken.
module input_capture_frequency_meter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  icfm_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output icfm_pkg::out_word_t        out_word,
  input  logic                       cfg_wr_en,
  input  logic [icfm_pkg::REF_W-1:0] cfg_wr_data
);

  icfm_pkg::cmd_t cmd;

  icfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_word.opcode),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  icfm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .cmd         (cmd),
    .out_word    (out_word)
  );

  a_timeout_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.timeout) |=>
      (out_valid && out_word.timed_out && (out_word.frequency_tenths == '0)))
    else $error("timeout result not formed correctly");

  a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.zero_period) |->
      (out_word.frequency_tenths == icfm_pkg::FREQ_MAX))
    else $error("zero period without saturated frequency");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.timed_out && out_word.zero_period))
    else $error("timeout and zero period flagged together");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.div_start) |=> in_stall)
    else $error("input accepted during divide");

endmodule
